// ===== hdl/alarm_panel_with_code_lockout_top_assert.svh =====
// ---------------------------------------------------------------------------
// Alarm panel assertion macros
// Concurrent checks clocked on aclk; AP_ASSERT is reset-qualified; empty under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ALARM_PANEL_WITH_CODE_LOCKOUT_TOP_ASSERT_SVH
`define ALARM_PANEL_WITH_CODE_LOCKOUT_TOP_ASSERT_SVH

`ifndef SYNTH
// implication check, disabled during reset
`define AP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("alarm panel check failed");
// invariant check, also sampled during reset
`define AP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("alarm panel invariant failed");
`else
`define AP_ASSERT(lbl, prop)
`define AP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/apcl_pkg.sv =====
// ---------------------------------------------------------------------------
// Alarm panel package
// Constants, register map and the expected-key lookup.
// ---------------------------------------------------------------------------
package apcl_pkg;

    localparam int CODE_LENGTH = 4;
    localparam int KEY_POS_W   = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int PADDR_W     = 5;

    localparam logic [7:0] KEY_NONE  = 8'd0;
    localparam logic [7:0] KEY_ENTER = 8'd35;
    localparam logic [7:0] KEY_RESET = 8'd48;

    localparam logic signed [15:0] TEMP_LIMIT_RST = 16'sd800;
    localparam logic [11:0]        GAS_LIMIT_RST  = 12'd0;
    localparam logic [31:0]        CODE_KEYS_RST  = 32'h3138_3035;
    localparam logic [15:0]        BLINK_GAS_RST  = 16'd1000;
    localparam logic [15:0]        BLINK_TEMP_RST = 16'd500;
    localparam logic [15:0]        BLINK_BOTH_RST = 16'd100;
    localparam logic [9:0]         TICK_MS_RST    = 10'd10;
    localparam logic [3:0]         MAX_WRONG_RST  = 4'd5;
    localparam logic [3:0]         WRONG_SAT      = 4'd15;

    typedef enum logic [2:0] {
        REG_TEMP_LIMIT,
        REG_GAS_LIMIT,
        REG_CODE_KEYS,
        REG_BLINK_GAS,
        REG_BLINK_TEMP,
        REG_BLINK_BOTH,
        REG_TICK_MS,
        REG_MAX_WRONG
    } cfg_reg_t;

    // expected key at ring slot i; slots past the fourth expect 0
    function automatic logic [7:0] exp_key(input logic [31:0] code, input int i);
        logic [7:0] k;
        k = 8'd0;
        if (i < 4) begin
            k = code[(31 - 8 * i) -: 8];
        end
        return k;
    endfunction

endpackage

// ===== hdl/alarm_panel_with_code_lockout_top.sv =====
// An s_ beat passes the input register, then the result register, on its way to m_.
// Throughput: one beat per cycle unless m_ stalls; the tick logic between registers is one pass.
// Back-pressure on m_ stalls both stages; s_ready follows the free input slot.
// Reset (aresetn low, synchronous): registers to defaults, latches and counters clear,
// key ring to '0'. No clearing pass; the block takes beats right after reset.
// ---------------------------------------------------------------------------
// Alarm panel with code lockout, top level
// Sensor latches, blinking alarm LED, keypad code check with lockout.
// ---------------------------------------------------------------------------
`include "alarm_panel_with_code_lockout_top_assert.svh"

module alarm_panel_with_code_lockout_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [apcl_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input tick channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [15:0]           s_temperature,
    input  logic [11:0]                  s_gas_level,
    input  logic [7:0]                   s_key,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_alarm_led,
    output logic                         m_incorrect_led,
    output logic                         m_blocked_led,
    output logic                         m_alarm_active,
    output logic                         m_gas_detected,
    output logic                         m_overtemp_detected
);
    import apcl_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [15:0] temp_limit_reg;
    logic [11:0]        gas_limit_reg;
    logic [31:0]        code_keys_reg;
    logic [15:0]        blink_gas_reg;
    logic [15:0]        blink_temp_reg;
    logic [15:0]        blink_both_reg;
    logic [9:0]         tick_ms_reg;
    logic [3:0]         max_wrong_reg;

    logic     cfg_wr;
    cfg_reg_t cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_limit_reg <= TEMP_LIMIT_RST;
            gas_limit_reg  <= GAS_LIMIT_RST;
            code_keys_reg  <= CODE_KEYS_RST;
            blink_gas_reg  <= BLINK_GAS_RST;
            blink_temp_reg <= BLINK_TEMP_RST;
            blink_both_reg <= BLINK_BOTH_RST;
            tick_ms_reg    <= TICK_MS_RST;
            max_wrong_reg  <= MAX_WRONG_RST;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_TEMP_LIMIT: temp_limit_reg <= pwdata[15:0];
                REG_GAS_LIMIT:  gas_limit_reg  <= pwdata[11:0];
                REG_CODE_KEYS:  code_keys_reg  <= pwdata;
                REG_BLINK_GAS:  blink_gas_reg  <= pwdata[15:0];
                REG_BLINK_TEMP: blink_temp_reg <= pwdata[15:0];
                REG_BLINK_BOTH: blink_both_reg <= pwdata[15:0];
                REG_TICK_MS:    tick_ms_reg    <= pwdata[9:0];
                REG_MAX_WRONG:  max_wrong_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // read mux; temp_limit reads back sign-extended
    always_comb begin
        unique case (cfg_sel)
            REG_TEMP_LIMIT: prdata = {{16{temp_limit_reg[15]}}, temp_limit_reg};
            REG_GAS_LIMIT:  prdata = {20'd0, gas_limit_reg};
            REG_CODE_KEYS:  prdata = code_keys_reg;
            REG_BLINK_GAS:  prdata = {16'd0, blink_gas_reg};
            REG_BLINK_TEMP: prdata = {16'd0, blink_temp_reg};
            REG_BLINK_BOTH: prdata = {16'd0, blink_both_reg};
            REG_TICK_MS:    prdata = {22'd0, tick_ms_reg};
            REG_MAX_WRONG:  prdata = {28'd0, max_wrong_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- handshake / pipeline control ----------------
    // in_vld_reg: a beat sits in the input register.
    // out_free: result register empty or draining this cycle.
    // tick_fire: the tick is processed and state commits.
    logic in_vld_reg;
    logic out_vld_reg;
    logic out_free;
    logic tick_fire;

    assign out_free  = !out_vld_reg || m_ready;
    assign tick_fire = in_vld_reg && out_free;
    assign s_ready   = !in_vld_reg || out_free;
    assign m_valid   = out_vld_reg;

    logic signed [15:0] temp_reg;
    logic [11:0]        gas_reg;
    logic [7:0]         key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            temp_reg <= s_temperature;
            gas_reg  <= s_gas_level;
            key_reg  <= s_key;
        end
    end

    // ---------------- tick state ----------------
    logic                 alarm_on_reg,     alarm_on_next;
    logic                 gas_latch_reg,    gas_latch_next;
    logic                 heat_latch_reg,   heat_latch_next;
    logic                 wrong_flag_reg,   wrong_flag_next;
    logic                 blocked_reg,      blocked_next;
    logic [3:0]           wrong_cnt_reg,    wrong_cnt_next;
    logic [15:0]          elapsed_reg,      elapsed_next;
    logic                 led_reg,          led_next;
    logic [KEY_POS_W-1:0] key_pos_reg,      key_pos_next;
    logic [1:0]           enter_cnt_reg,    enter_cnt_next;
    logic [7:0]           keys_reg  [CODE_LENGTH];
    logic [7:0]           keys_next [CODE_LENGTH];

    // ---------------- tick logic ----------------
    logic        alarm_s;      // alarm after sensor check
    logic        gas_s;
    logic        heat_s;
    logic [16:0] elapsed_sum;
    logic [15:0] elapsed_sat;
    logic [15:0] period;
    logic        have_period;
    logic        code_ok;
    logic        is_enter;
    logic        is_code_key;

    always_comb begin
        // sensors latch the alarm; alarm off drops both latches
        alarm_s = alarm_on_reg || (temp_reg > temp_limit_reg) || (gas_reg > gas_limit_reg);
        heat_s  = alarm_s && (heat_latch_reg || (temp_reg > temp_limit_reg));
        gas_s   = alarm_s && (gas_latch_reg || (gas_reg > gas_limit_reg));

        // blink accumulator, saturating
        elapsed_sum = {1'b0, elapsed_reg} + {7'd0, tick_ms_reg};
        elapsed_sat = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];

        priority if (gas_s && heat_s) begin
            period = blink_both_reg;
        end else if (gas_s) begin
            period = blink_gas_reg;
        end else begin
            period = blink_temp_reg;
        end
        have_period = gas_s || heat_s;

        elapsed_next = elapsed_sat;
        led_next     = led_reg;
        if (!alarm_s) begin
            led_next = 1'b0;
        end else if (have_period && (elapsed_sat >= period)) begin
            elapsed_next = 16'd0;
            led_next     = !led_reg;
        end

        // code compare over the ring
        code_ok = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            if (keys_reg[i] != exp_key(code_keys_reg, i)) begin
                code_ok = 1'b0;
            end
        end

        is_enter    = (key_reg == KEY_ENTER);
        is_code_key = (key_reg != KEY_NONE) && !is_enter;

        alarm_on_next   = alarm_s;
        gas_latch_next  = gas_s;
        heat_latch_next = heat_s;
        wrong_flag_next = wrong_flag_reg;
        blocked_next    = blocked_reg;
        wrong_cnt_next  = wrong_cnt_reg;
        key_pos_next    = key_pos_reg;
        enter_cnt_next  = enter_cnt_reg;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            keys_next[i] = keys_reg[i];
        end

        // keypad; lockout is checked against the count before this tick
        if (blocked_reg || (wrong_cnt_reg >= max_wrong_reg)) begin
            blocked_next = 1'b1;
        end else begin
            if (is_code_key) begin
                keys_next[key_pos_reg] = key_reg;
                key_pos_next = (key_pos_reg == KEY_POS_W'(CODE_LENGTH - 1)) ?
                               '0 : key_pos_reg + KEY_POS_W'(1);
            end
            if (is_enter) begin
                if (wrong_flag_reg) begin
                    // second enter acknowledges the wrong code
                    if (enter_cnt_reg != 2'd0) begin
                        enter_cnt_next  = 2'd0;
                        key_pos_next    = '0;
                        wrong_flag_next = 1'b0;
                    end else begin
                        enter_cnt_next = enter_cnt_reg + 2'd1;
                    end
                end else if (alarm_s) begin
                    if (code_ok) begin
                        alarm_on_next  = 1'b0;
                        wrong_cnt_next = 4'd0;
                    end else begin
                        wrong_flag_next = 1'b1;
                        if (wrong_cnt_reg != WRONG_SAT) begin
                            wrong_cnt_next = wrong_cnt_reg + 4'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_on_reg   <= 1'b0;
            gas_latch_reg  <= 1'b0;
            heat_latch_reg <= 1'b0;
            wrong_flag_reg <= 1'b0;
            blocked_reg    <= 1'b0;
            wrong_cnt_reg  <= 4'd0;
            elapsed_reg    <= 16'd0;
            led_reg        <= 1'b0;
            key_pos_reg    <= '0;
            enter_cnt_reg  <= 2'd0;
            for (int i = 0; i < CODE_LENGTH; i++) begin
                keys_reg[i] <= KEY_RESET;
            end
        end else if (tick_fire) begin
            alarm_on_reg   <= alarm_on_next;
            gas_latch_reg  <= gas_latch_next;
            heat_latch_reg <= heat_latch_next;
            wrong_flag_reg <= wrong_flag_next;
            blocked_reg    <= blocked_next;
            wrong_cnt_reg  <= wrong_cnt_next;
            elapsed_reg    <= elapsed_next;
            led_reg        <= led_next;
            key_pos_reg    <= key_pos_next;
            enter_cnt_reg  <= enter_cnt_next;
            for (int i = 0; i < CODE_LENGTH; i++) begin
                keys_reg[i] <= keys_next[i];
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_fire) begin
            m_alarm_led         <= led_next;
            m_incorrect_led     <= wrong_flag_next;
            m_blocked_led       <= blocked_next;
            m_alarm_active      <= alarm_on_next;
            m_gas_detected      <= gas_latch_next;
            m_overtemp_detected <= heat_latch_next;
        end
    end

    // ---------------- checks ----------------
    // lockout never releases
    `AP_ASSERT(a_blocked_sticky, blocked_reg |=> blocked_reg)
    // enter counter only ever holds 0 or 1; the counter is unknown before the first reset edge
    `AP_ASSERT_ALWAYS(a_enter_cnt_range, !aresetn || !enter_cnt_reg[1])
    // a beat in the input register is not dropped while the result side stalls
    `AP_ASSERT(a_in_hold, (in_vld_reg && !out_free) |=> in_vld_reg)
    // a result beat committed with its tick state
    `AP_ASSERT(a_result_match, tick_fire |=> (m_valid && m_alarm_active == alarm_on_reg))

endmodule
